@@ design/rv32i_execute_unit_defines.svh @@
// ----------------------------------------------------------------------------
// RV32I execute unit assertion macros
// Concurrent checks on clk; RVX_ASSERT checks are disabled while rst_n is low, RVX_ASSERT_ALWAYS checks are not.
// ----------------------------------------------------------------------------
`ifndef RV32I_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RVX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rvx assertion failed");
`define RVX_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rvx assertion failed");
`else
`define RVX_ASSERT(lbl, prop)
`define RVX_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/rvx_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit package
// Opcodes, function codes and trap codes.
// ----------------------------------------------------------------------------
package rvx_pkg;

  typedef logic [2:0] trap_t;

  localparam trap_t TRAP_OK      = 3'd0;
  localparam trap_t TRAP_ILLEGAL = 3'd1;
  localparam trap_t TRAP_ECALL   = 3'd2;
  localparam trap_t TRAP_BREAK   = 3'd3;
  localparam trap_t TRAP_LOAD    = 3'd4;
  localparam trap_t TRAP_STORE   = 3'd5;

  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0]  F3_PRIV    = 3'd0;
  localparam logic [31:0] IMM_ECALL  = 32'd0;
  localparam logic [31:0] IMM_EBREAK = 32'd1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  localparam logic [31:0] PC_STEP = 32'd4;

endpackage

@@ design/rvx_in_if.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit instruction channel
// Valid/ready channel carrying one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface rvx_in_if;
  logic               valid;
  logic               ready;
  logic        [6:0]  opcode;
  logic        [2:0]  funct3;
  logic        [6:0]  funct7;
  logic        [4:0]  dest_reg;
  logic        [4:0]  src1_reg;
  logic        [4:0]  src2_reg;
  logic signed [31:0] immediate;

  modport source (output valid, opcode, funct3, funct7, dest_reg, src1_reg, src2_reg,
                  immediate, input ready);
  modport sink (input valid, opcode, funct3, funct7, dest_reg, src1_reg, src2_reg,
                immediate, output ready);
endinterface

@@ design/rvx_out_if.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit result channel
// Valid/ready channel carrying one execution result per transfer.
// ----------------------------------------------------------------------------
interface rvx_out_if;
  import rvx_pkg::*;
  logic        valid;
  logic        ready;
  trap_t       trap_code;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [31:0] written_value;

  modport source (output valid, trap_code, next_pc, reg_written, written_value,
                  input ready);
  modport sink (input valid, trap_code, next_pc, reg_written, written_value,
                output ready);
endinterface

@@ design/rvx_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/rv32i_execute_unit.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit
// Stages from instruction transfer to result valid: read/execute, memory/writeback,
// output register. Throughput: one instruction per cycle while the result channel
// does not stall, set by the register file and data memory ports with forwarding.
// Reset: synchronous rst_n clears pc, pipeline valids and register valid bits.
// ----------------------------------------------------------------------------
`include "rv32i_execute_unit_defines.svh"

module rv32i_execute_unit #(
  parameter int unsigned MEM_WORD_ADDR_BITS = 14
) (
  input logic      clk,
  input logic      rst_n,
  rvx_in_if.sink   in_ch,
  rvx_out_if.source out_ch
);
  import rvx_pkg::*;

  localparam int unsigned MEM_DEPTH = 1 << MEM_WORD_ADDR_BITS;
  localparam int unsigned AHI = MEM_WORD_ADDR_BITS + 2;

  logic adv, acc;

  logic        out_v_r;
  trap_t       out_trap_r;
  logic [31:0] out_pc_r;
  logic        out_wr_r;
  logic [31:0] out_val_r;

  logic        s1_v_r;
  logic [6:0]  s1_opc_r;
  logic [2:0]  s1_f3_r;
  logic [6:0]  s1_f7_r;
  logic [4:0]  s1_rd_r, s1_rs1_r, s1_rs2_r;
  logic [31:0] s1_imm_r;

  logic        s2_v_r, s2_wr_r, s2_ld_r;
  trap_t       s2_trap_r;
  logic [31:0] s2_pc_r, s2_val_r;
  logic [2:0]  s2_f3_r;
  logic [1:0]  s2_off_r;
  logic [4:0]  s2_rd_r;
  logic [31:0] s2_val;

  logic        wb_v_r;
  logic [4:0]  wb_rd_r;
  logic [31:0] wb_val_r;

  logic [31:0] rf_vld_r;
  logic [31:0] pc_r;
  logic [31:0] rf_a_q, rf_b_q;
  logic        rf_we;

  logic [31:0] op_a, op_b, op2, agen, s1_val, ld_word, ld_shift;
  logic [4:0]  shamt;
  logic        is_reg, s1_wr, s1_ld, s1_st, addr_ok;
  trap_t       s1_trap;
  logic [3:0]  st_mask;
  logic [31:0] st_data;
  logic [MEM_WORD_ADDR_BITS-1:0] mem_addr;

  assign adv         = !out_v_r || out_ch.ready;
  assign acc         = in_ch.valid && adv;
  assign in_ch.ready = adv;
  assign rf_we       = adv && s2_v_r && s2_wr_r;

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(s2_rd_r), .wdata(s2_val),
    .re(adv), .raddr(in_ch.src1_reg), .rdata(rf_a_q)
  );

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(s2_rd_r), .wdata(s2_val),
    .re(adv), .raddr(in_ch.src2_reg), .rdata(rf_b_q)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    rvx_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
      .clk(clk), .we(adv && s1_v_r && s1_st && st_mask[i]), .waddr(mem_addr),
      .wdata(st_data[8*i +: 8]), .re(adv), .raddr(mem_addr),
      .rdata(ld_word[8*i +: 8])
    );
  end

  always_comb begin
    if (s2_v_r && s2_wr_r && s2_rd_r == s1_rs1_r) begin
      op_a = s2_val;
    end else if (wb_v_r && wb_rd_r == s1_rs1_r) begin
      op_a = wb_val_r;
    end else if (rf_vld_r[s1_rs1_r]) begin
      op_a = rf_a_q;
    end else begin
      op_a = '0;
    end
    if (s2_v_r && s2_wr_r && s2_rd_r == s1_rs2_r) begin
      op_b = s2_val;
    end else if (wb_v_r && wb_rd_r == s1_rs2_r) begin
      op_b = wb_val_r;
    end else if (rf_vld_r[s1_rs2_r]) begin
      op_b = rf_b_q;
    end else begin
      op_b = '0;
    end
  end

  assign is_reg   = (s1_opc_r == OPC_OP);
  assign op2      = is_reg ? op_b : s1_imm_r;
  assign shamt    = op2[4:0];
  assign agen     = op_a + s1_imm_r;
  assign mem_addr = agen[AHI-1:2];

  always_comb begin
    addr_ok = (agen[31:AHI] == '0);
    case (s1_f3_r[1:0])
      SZ_BYTE: ;
      SZ_HALF: addr_ok = addr_ok && !agen[0];
      default: addr_ok = addr_ok && (agen[1:0] == 2'd0);
    endcase
  end

  always_comb begin
    case (s1_f3_r[1:0])
      SZ_BYTE: begin
        st_mask = 4'b0001 << agen[1:0];
        st_data = {4{op_b[7:0]}};
      end
      SZ_HALF: begin
        st_mask = 4'b0011 << agen[1:0];
        st_data = {2{op_b[15:0]}};
      end
      default: begin
        st_mask = 4'b1111;
        st_data = op_b;
      end
    endcase
  end

  always_comb begin
    s1_trap = TRAP_OK;
    s1_val  = '0;
    s1_wr   = 1'b0;
    s1_ld   = 1'b0;
    s1_st   = 1'b0;
    unique case (s1_opc_r) inside
      OPC_OP_IMM, OPC_OP: begin
        s1_wr = 1'b1;
        unique case (s1_f3_r)
          F3_ADD: begin
            if (!is_reg) s1_val = agen;
            else if (s1_f7_r == F7_BASE) s1_val = op_a + op_b;
            else if (s1_f7_r == F7_ALT) s1_val = op_a - op_b;
            else s1_trap = TRAP_ILLEGAL;
          end
          F3_SLL: begin
            if (s1_f7_r == F7_BASE) s1_val = op_a << shamt;
            else s1_trap = TRAP_ILLEGAL;
          end
          F3_SR: begin
            if (s1_f7_r == F7_BASE) s1_val = op_a >> shamt;
            else if (s1_f7_r == F7_ALT) s1_val = 32'($signed(op_a) >>> shamt);
            else s1_trap = TRAP_ILLEGAL;
          end
          default: begin
            if (is_reg && s1_f7_r != F7_BASE) begin
              s1_trap = TRAP_ILLEGAL;
            end else begin
              case (s1_f3_r)
                F3_SLT:  s1_val = {31'd0, $signed(op_a) < $signed(op2)};
                F3_SLTU: s1_val = {31'd0, op_a < op2};
                F3_XOR:  s1_val = op_a ^ op2;
                F3_OR:   s1_val = op_a | op2;
                default: s1_val = op_a & op2;
              endcase
            end
          end
        endcase
      end
      OPC_LUI: begin
        s1_wr  = 1'b1;
        s1_val = s1_imm_r;
      end
      OPC_AUIPC: begin
        s1_wr  = 1'b1;
        s1_val = pc_r + s1_imm_r;
      end
      OPC_LOAD: begin
        if (s1_f3_r == F3_SLTU || s1_f3_r == F3_OR || s1_f3_r == F3_AND) begin
          s1_trap = TRAP_ILLEGAL;
        end else if (!addr_ok) begin
          s1_trap = TRAP_LOAD;
        end else begin
          s1_wr = 1'b1;
          s1_ld = 1'b1;
        end
      end
      OPC_STORE: begin
        if (s1_f3_r[2] || s1_f3_r == F3_SLTU) s1_trap = TRAP_ILLEGAL;
        else if (!addr_ok) s1_trap = TRAP_STORE;
        else s1_st = 1'b1;
      end
      OPC_SYSTEM: begin
        if (s1_f3_r == F3_PRIV && s1_imm_r == IMM_ECALL) s1_trap = TRAP_ECALL;
        else if (s1_f3_r == F3_PRIV && s1_imm_r == IMM_EBREAK) s1_trap = TRAP_BREAK;
        else s1_trap = TRAP_ILLEGAL;
      end
      default: s1_trap = TRAP_ILLEGAL;
    endcase
    if (s1_trap != TRAP_OK || s1_rd_r == 5'd0) begin
      s1_wr  = 1'b0;
      s1_val = '0;
      s1_ld  = 1'b0;
    end
  end

  assign ld_shift = ld_word >> {s2_off_r, 3'b000};

  always_comb begin
    s2_val = s2_val_r;
    if (s2_ld_r) begin
      case (s2_f3_r)
        F3_LB:   s2_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
        F3_LH:   s2_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
        F3_LBU:  s2_val = {24'd0, ld_shift[7:0]};
        F3_LHU:  s2_val = {16'd0, ld_shift[15:0]};
        default: s2_val = ld_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      wb_v_r   <= 1'b0;
      rf_vld_r <= '0;
      pc_r     <= '0;
    end else if (adv) begin
      s1_v_r  <= acc;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
      wb_v_r  <= rf_we;
      if (rf_we) begin
        rf_vld_r[s2_rd_r] <= 1'b1;
      end
      if (s1_v_r && s1_trap == TRAP_OK) begin
        pc_r <= pc_r + PC_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_opc_r   <= in_ch.opcode;
      s1_f3_r    <= in_ch.funct3;
      s1_f7_r    <= in_ch.funct7;
      s1_rd_r    <= in_ch.dest_reg;
      s1_rs1_r   <= in_ch.src1_reg;
      s1_rs2_r   <= in_ch.src2_reg;
      s1_imm_r   <= in_ch.immediate;
      s2_trap_r  <= s1_trap;
      s2_pc_r    <= (s1_trap == TRAP_OK) ? pc_r + PC_STEP : pc_r;
      s2_wr_r    <= s1_wr;
      s2_ld_r    <= s1_ld;
      s2_val_r   <= s1_val;
      s2_f3_r    <= s1_f3_r;
      s2_off_r   <= agen[1:0];
      s2_rd_r    <= s1_rd_r;
      wb_rd_r    <= s2_rd_r;
      wb_val_r   <= s2_val;
      out_trap_r <= s2_trap_r;
      out_pc_r   <= s2_pc_r;
      out_wr_r   <= s2_wr_r;
      out_val_r  <= s2_val;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.trap_code     = out_trap_r;
  assign out_ch.next_pc       = out_pc_r;
  assign out_ch.reg_written   = out_wr_r;
  assign out_ch.written_value = out_val_r;

  `RVX_ASSERT(a_trap_no_write, s2_v_r && (s2_trap_r != TRAP_OK) |-> !s2_wr_r)
  `RVX_ASSERT(a_pc_hold, adv && s1_v_r && (s1_trap != TRAP_OK) |=> pc_r == $past(pc_r))
  `RVX_ASSERT(a_x0_never_written, rf_we |-> s2_rd_r != 5'd0)
  `RVX_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_v_r && !s1_v_r && !s2_v_r)

endmodule

@@ tb/rvx_exec_checker.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit checker
// Watches the instruction and result channels. Every instruction transfer is
// executed on a private copy of the register file, pc and data memory. The
// result that follows is expected on the result channel, in order and field
// by field. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module rvx_exec_checker #(
  parameter int unsigned MEM_WORD_ADDR_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  rvx_in_if    in_ch,
  rvx_out_if   out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   retired,
  output int   trapped
);
  import rvx_pkg::*;

  typedef struct packed {
    trap_t       trap_code;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [31:0] written_value;
  } exec_result_t;

  logic [31:0]  gpr [32];
  logic [31:0]  pc;
  logic [31:0]  dmem [int unsigned];
  exec_result_t pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    retired     = 0;
    trapped     = 0;
    pc          = '0;
    foreach (gpr[i]) gpr[i] = '0;
  end

  function automatic bit access_ok(logic [31:0] addr, int unsigned size);
    logic [63:0] word_idx;
    word_idx = {32'd0, addr} >> 2;
    return ((addr & (size - 1)) == 0) && (word_idx < (64'd1 << MEM_WORD_ADDR_BITS));
  endfunction

  function automatic logic [31:0] word_at(logic [31:0] addr);
    int unsigned idx;
    idx = addr >> 2;
    return dmem.exists(idx) ? dmem[idx] : 32'd0;
  endfunction

  function automatic exec_result_t execute(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                           logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [31:0] imm);
    exec_result_t r;
    logic [31:0]  a, b, op2, addr, v, mask;
    logic [4:0]   sh;
    int unsigned  size, idx;
    bit           wr;
    a = gpr[rs1];
    b = gpr[rs2];
    r.trap_code = TRAP_OK;
    v = '0;
    wr = 1'b0;
    if (opc == OPC_OP_IMM || opc == OPC_OP) begin
      op2 = (opc == OPC_OP) ? b : imm;
      sh = op2[4:0];
      wr = 1'b1;
      case (f3)
        F3_ADD: begin
          if (opc == OPC_OP_IMM) v = a + imm;
          else if (f7 == F7_BASE) v = a + b;
          else if (f7 == F7_ALT) v = a - b;
          else r.trap_code = TRAP_ILLEGAL;
        end
        F3_SLL: begin
          if (f7 == F7_BASE) v = a << sh;
          else r.trap_code = TRAP_ILLEGAL;
        end
        F3_SR: begin
          if (f7 == F7_BASE) v = a >> sh;
          else if (f7 == F7_ALT) v = $signed(a) >>> sh;
          else r.trap_code = TRAP_ILLEGAL;
        end
        default: begin
          if (opc == OPC_OP && f7 != F7_BASE) r.trap_code = TRAP_ILLEGAL;
          else begin
            case (f3)
              F3_SLT:  v = ($signed(a) < $signed(op2)) ? 32'd1 : 32'd0;
              F3_SLTU: v = (a < op2) ? 32'd1 : 32'd0;
              F3_XOR:  v = a ^ op2;
              F3_OR:   v = a | op2;
              default: v = a & op2;
            endcase
          end
        end
      endcase
    end else if (opc == OPC_LUI) begin
      wr = 1'b1;
      v = imm;
    end else if (opc == OPC_AUIPC) begin
      wr = 1'b1;
      v = pc + imm;
    end else if (opc == OPC_LOAD) begin
      addr = a + imm;
      size = (f3[1:0] == SZ_BYTE) ? 1 : (f3[1:0] == SZ_HALF) ? 2 : 4;
      if (f3 == F3_SLTU || f3 > F3_LHU) r.trap_code = TRAP_ILLEGAL;
      else if (!access_ok(addr, size)) r.trap_code = TRAP_LOAD;
      else begin
        v = word_at(addr) >> (8 * addr[1:0]);
        case (f3)
          F3_LB:  v = {{24{v[7]}}, v[7:0]};
          F3_LH:  v = {{16{v[15]}}, v[15:0]};
          F3_LBU: v = {24'd0, v[7:0]};
          F3_LHU: v = {16'd0, v[15:0]};
          default: ;
        endcase
        wr = 1'b1;
      end
    end else if (opc == OPC_STORE) begin
      addr = a + imm;
      size = (f3 == F3_SB) ? 1 : (f3 == F3_SH) ? 2 : 4;
      if (f3 > F3_SW) r.trap_code = TRAP_ILLEGAL;
      else if (!access_ok(addr, size)) r.trap_code = TRAP_STORE;
      else begin
        idx = addr >> 2;
        mask = (size == 1) ? 32'hFF : (size == 2) ? 32'hFFFF : 32'hFFFF_FFFF;
        mask = mask << (8 * addr[1:0]);
        dmem[idx] = (word_at(addr) & ~mask) | ((b << (8 * addr[1:0])) & mask);
      end
    end else if (opc == OPC_SYSTEM) begin
      if (f3 == F3_PRIV && imm == IMM_ECALL) r.trap_code = TRAP_ECALL;
      else if (f3 == F3_PRIV && imm == IMM_EBREAK) r.trap_code = TRAP_BREAK;
      else r.trap_code = TRAP_ILLEGAL;
    end else begin
      r.trap_code = TRAP_ILLEGAL;
    end
    if (r.trap_code != TRAP_OK || rd == 5'd0) begin
      wr = 1'b0;
      v = '0;
    end
    if (wr) gpr[rd] = v;
    if (r.trap_code == TRAP_OK) pc = pc + PC_STEP;
    r.next_pc = pc;
    r.reg_written = wr;
    r.written_value = v;
    return r;
  endfunction

  task automatic report(string msg);
    $display("result %0d: %s", retired, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(execute(in_ch.opcode, in_ch.funct3, in_ch.funct7,
                                          in_ch.dest_reg, in_ch.src1_reg, in_ch.src2_reg,
                                          in_ch.immediate));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report("transfer with nothing predicted");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.trap_code !== want.trap_code)
            report($sformatf("trap_code is 0x%08h, predicted 0x%08h",
                             32'(out_ch.trap_code), 32'(want.trap_code)));
          if (out_ch.next_pc !== want.next_pc)
            report($sformatf("next_pc is 0x%08h, predicted 0x%08h",
                             out_ch.next_pc, want.next_pc));
          if (out_ch.reg_written !== want.reg_written)
            report($sformatf("reg_written is 0x%08h, predicted 0x%08h",
                             32'(out_ch.reg_written), 32'(want.reg_written)));
          if (out_ch.written_value !== want.written_value)
            report($sformatf("written_value is 0x%08h, predicted 0x%08h",
                             out_ch.written_value, want.written_value));
          if (want.trap_code != TRAP_OK) trapped++;
        end
        retired++;
      end
      outstanding = pending_results.size();
    end
  end
endmodule

@@ tb/tb_rv32i_execute_unit.sv @@
// ----------------------------------------------------------------------------
// RV32I execute unit testbench
// Drives directed instructions (ALU extremes, every operation, loads and
// stores of each size, misaligned and out-of-range accesses, system calls,
// illegal encodings), then random instruction streams under four idle and
// stall mixes with one long result hold-off. Loads only touch words that a
// word store has defined. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rv32i_execute_unit;
  import rvx_pkg::*;

  localparam int unsigned MEM_BITS   = 14;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          PHASE_LEN  = 350;
  localparam int          WINDOW     = 256;
  localparam logic [31:0] LAST_WORD  = (32'd1 << MEM_BITS) - 1;

  logic clk;
  logic rst_n;
  int   mismatches, outstanding, retired, trapped;
  int   cycles;
  int   send_idle_pct, recv_stall_pct;
  int   hold_left;
  bit   hold_req;
  int   sent;
  logic [31:0] defined_words [$];

  rvx_in_if  in_if ();
  rvx_out_if out_if ();

  rv32i_execute_unit #(.MEM_WORD_ADDR_BITS(MEM_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  rvx_exec_checker #(.MEM_WORD_ADDR_BITS(MEM_BITS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .retired     (retired),
    .trapped     (trapped)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic issue(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7, logic [4:0] rd,
                       logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm);
    in_if.opcode    <= opc;
    in_if.funct3    <= f3;
    in_if.funct7    <= f7;
    in_if.dest_reg  <= rd;
    in_if.src1_reg  <= rs1;
    in_if.src2_reg  <= rs2;
    in_if.immediate <= imm;
    in_if.valid     <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic store_word(logic [31:0] word, logic [4:0] rs2);
    issue(OPC_STORE, F3_SW, F7_BASE, 5'd0, 5'd0, rs2, word << 2);
    defined_words.push_back(word);
  endtask

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 4095)) - 2048);
      1: return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] rand_f7();
    int r;
    r = $urandom_range(0, 9);
    return (r < 5) ? F7_BASE : (r < 9) ? F7_ALT : 7'($urandom);
  endfunction

  task automatic random_item();
    int          r;
    logic [2:0]  f3;
    logic [31:0] addr;
    r = $urandom_range(0, 99);
    f3 = 3'($urandom);
    if (r < 28) begin
      issue(OPC_OP_IMM, f3, rand_f7(), 5'($urandom), 5'($urandom), 5'($urandom), rand_imm());
    end else if (r < 52) begin
      issue(OPC_OP, f3, rand_f7(), 5'($urandom), 5'($urandom), 5'($urandom), rand_imm());
    end else if (r < 56) begin
      issue(OPC_LUI, f3, 7'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
            $urandom & 32'hFFFF_F000);
    end else if (r < 60) begin
      issue(OPC_AUIPC, f3, 7'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
            $urandom & 32'hFFFF_F000);
    end else if (r < 75) begin
      if ($urandom_range(0, 3) == 0) begin
        issue(OPC_STORE, f3, 7'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
              rand_imm());
      end else if ($urandom_range(0, 1) == 0) begin
        store_word($urandom_range(0, WINDOW - 1), 5'($urandom));
      end else begin
        issue(OPC_STORE, 3'($urandom_range(0, 1)), 7'($urandom), 5'($urandom), 5'd0,
              5'($urandom), $urandom_range(0, 4 * WINDOW - 1));
      end
    end else if (r < 92) begin
      if (defined_words.size() == 0 || $urandom_range(0, 5) == 0) begin
        addr = $urandom | 32'h8000_0000;
      end else begin
        addr = (defined_words[$urandom_range(0, defined_words.size() - 1)] << 2)
               + $urandom_range(0, 3);
      end
      case ($urandom_range(0, 5))
        0: f3 = F3_LB;
        1: f3 = F3_LH;
        2: f3 = F3_LW;
        3: f3 = F3_LBU;
        4: f3 = F3_LHU;
        default: ;
      endcase
      issue(OPC_LOAD, f3, 7'($urandom), 5'($urandom), 5'd0, 5'($urandom), addr);
    end else if (r < 95) begin
      issue(OPC_SYSTEM, ($urandom_range(0, 3) == 0) ? f3 : F3_PRIV, 7'($urandom),
            5'($urandom), 5'($urandom), 5'($urandom), $urandom_range(0, 2));
    end else begin
      // noise; a load here is pushed out of memory so no undefined word is read
      addr = $urandom;
      f3 = 3'($urandom);
      r = $urandom_range(0, 127);
      if (7'(r) == OPC_LOAD) begin
        issue(OPC_LOAD, f3, 7'($urandom), 5'($urandom), 5'd0, 5'($urandom),
              addr | 32'h8000_0000);
      end else begin
        issue(7'(r), f3, 7'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), addr);
      end
    end
  endtask

  initial begin
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    out_if.ready = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.funct3 = '0;
    in_if.funct7 = '0;
    in_if.dest_reg = '0;
    in_if.src1_reg = '0;
    in_if.src2_reg = '0;
    in_if.immediate = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OPC_LUI, 3'd0, F7_BASE, 5'd1, 5'd0, 5'd0, 32'h8000_0000);
    issue(OPC_OP_IMM, F3_ADD, F7_BASE, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
    issue(OPC_OP_IMM, F3_ADD, F7_BASE, 5'd31, 5'd0, 5'd0, 32'h0000_07FF);
    issue(OPC_OP, F3_ADD, F7_ALT, 5'd3, 5'd1, 5'd2, 32'd0);
    issue(OPC_OP, F3_ADD, F7_BASE, 5'd4, 5'd1, 5'd2, 32'd0);
    issue(OPC_OP_IMM, F3_SR, F7_ALT, 5'd5, 5'd1, 5'd0, 32'd31);
    issue(OPC_OP_IMM, F3_SR, F7_BASE, 5'd6, 5'd1, 5'd0, 32'd0);
    issue(OPC_OP, F3_SLL, F7_BASE, 5'd7, 5'd2, 5'd31, 32'd0);
    issue(OPC_OP, F3_SLT, F7_BASE, 5'd8, 5'd1, 5'd2, 32'd0);
    issue(OPC_OP_IMM, F3_SLTU, F7_BASE, 5'd9, 5'd1, 5'd0, 32'hFFFF_FFFF);
    issue(OPC_OP, F3_XOR, F7_BASE, 5'd10, 5'd1, 5'd2, 32'd0);
    issue(OPC_OP_IMM, F3_OR, F7_BASE, 5'd11, 5'd31, 5'd0, 32'h8000_0000);
    issue(OPC_OP, F3_AND, F7_ALT, 5'd12, 5'd1, 5'd2, 32'd0);
    issue(OPC_AUIPC, 3'd0, F7_BASE, 5'd0, 5'd0, 5'd0, 32'h7FFF_F000);
    store_word(32'd0, 5'd2);
    store_word(LAST_WORD, 5'd1);
    issue(OPC_LOAD, F3_LW, F7_BASE, 5'd13, 5'd0, 5'd0, LAST_WORD << 2);
    issue(OPC_STORE, F3_SB, F7_BASE, 5'd0, 5'd0, 5'd31, 32'd3);
    issue(OPC_STORE, F3_SH, F7_BASE, 5'd0, 5'd0, 5'd1, 32'd0);
    issue(OPC_LOAD, F3_LB, F7_BASE, 5'd14, 5'd0, 5'd0, 32'd3);
    issue(OPC_LOAD, F3_LHU, F7_BASE, 5'd15, 5'd0, 5'd0, 32'd2);
    issue(OPC_LOAD, F3_LH, F7_BASE, 5'd16, 5'd0, 5'd0, 32'd1);
    issue(OPC_LOAD, F3_LW, F7_BASE, 5'd17, 5'd0, 5'd0, (LAST_WORD << 2) + 4);
    issue(OPC_STORE, F3_SW, F7_BASE, 5'd0, 5'd0, 5'd1, 32'hFFFF_FFFC);
    issue(OPC_SYSTEM, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0, IMM_ECALL);
    issue(OPC_SYSTEM, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0, IMM_EBREAK);
    issue(7'h7F, 3'd0, F7_BASE, 5'd1, 5'd0, 5'd0, 32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 20 : 0;
      recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 20 : 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        while ($urandom_range(0, 99) < send_idle_pct) begin
          in_if.valid <= 1'b0;
          @(posedge clk);
        end
        random_item();
      end
    end
    in_if.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0 || retired < sent);
    repeat (10) @(posedge clk);
    $display("covered %0d instructions, %0d results, %0d of them traps", sent, retired,
             trapped);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ rv32i_execute_unit.f @@
+incdir+design
design/rvx_pkg.sv
design/rvx_in_if.sv
design/rvx_out_if.sv
design/rvx_ram.sv
design/rv32i_execute_unit.sv
tb/rvx_exec_checker.sv
tb/tb_rv32i_execute_unit.sv
